FILE: rtl/sucs_pkg.sv
`timescale 1ns / 1ps

package sucs_pkg;

	localparam int DEPTH_DEF = 64;
	localparam logic [6:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_SEARCH = 2'd2,
		FUNC_DUMP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_DUP    = 2'd2,
		STAT_ABSENT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SCAN_NEXT,
		OP_INS_PRIME,
		OP_UP_STEP,
		OP_PLACE,
		OP_DN_PRIME,
		OP_DN_STEP,
		OP_DUMP_STEP
	} dp_op_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    emit;
		status_t status;
		logic    last;
		logic    dump_val;
		cnt_op_t cnt_op;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
		logic  eq;
		logic  ge;
		logic  idx_last;
		logic  up_end;
		logic  dn_end;
	} sts_t;

endpackage

FILE: rtl/sucs_ram.sv
`timescale 1ns / 1ps

module sucs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sucs_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/sucs_datapath.sv
`timescale 1ns / 1ps

module sucs_datapath #(
	parameter int DEPTH = sucs_pkg::DEPTH_DEF,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sucs_pkg::cmd_t     cmd,
	output sucs_pkg::sts_t     sts,
	input  logic [1:0]         func,
	input  logic signed [7:0]  key,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [7:0]  value,
	output logic               last,
	output logic [6:0]         count
);

	localparam int CMPW = (CW > 7) ? CW : 7;

	logic [6:0]             cap_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          cnt_d;
	sucs_pkg::func_t        func_q;
	logic signed [7:0]      key_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          pos_q;
	logic                   done_q;
	sucs_pkg::status_t      status_q;
	logic signed [7:0]      value_q;
	logic                   last_q;
	logic [6:0]             count_q;

	logic [CW-1:0]          idx_p1;
	logic [CW-1:0]          idx_p2;
	logic [CW-1:0]          idx_m1;
	logic [CW-1:0]          idx_m2;
	logic [CW-1:0]          cnt_m1;
	logic [CW-1:0]          pos_p1;
	logic [7:0]             rdata;
	logic signed [7:0]      rkey;
	logic                   ge;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [7:0]             ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_p2 = idx_q + CW'(2);
	assign idx_m1 = idx_q - CW'(1);
	assign idx_m2 = idx_q - CW'(2);
	assign cnt_m1 = cnt_q - CW'(1);
	assign pos_p1 = pos_q + CW'(1);

	assign rkey = $signed(rdata);
	assign ge   = rkey >= key_q;

	assign sts.func     = func_q;
	assign sts.empty    = cnt_q == '0;
	assign sts.full     = (CMPW'(cnt_q) >= CMPW'(cap_q)) || (cnt_q >= CW'(DEPTH));
	assign sts.eq       = rkey == key_q;
	assign sts.ge       = ge;
	assign sts.idx_last = idx_p1 == cnt_q;
	assign sts.up_end   = idx_q == pos_p1;
	assign sts.dn_end   = idx_p2 == cnt_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rdata;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (cmd.op)
			sucs_pkg::OP_LOAD: begin
				ram_re = 1'b1;
			end
			sucs_pkg::OP_SCAN_NEXT, sucs_pkg::OP_DN_PRIME, sucs_pkg::OP_DUMP_STEP: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(idx_p1);
			end
			sucs_pkg::OP_INS_PRIME: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(cnt_m1);
			end
			sucs_pkg::OP_UP_STEP: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_re    = 1'b1;
				ram_raddr = AW'(idx_m2);
			end
			sucs_pkg::OP_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_q);
				ram_wdata = key_q;
			end
			sucs_pkg::OP_DN_STEP: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_re    = 1'b1;
				ram_raddr = AW'(idx_p2);
			end
			default: begin
			end
		endcase
	end

	sucs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_comb begin
		unique case (cmd.cnt_op)
			sucs_pkg::CNT_INC: cnt_d = cnt_q + CW'(1);
			sucs_pkg::CNT_DEC: cnt_d = cnt_m1;
			default:           cnt_d = cnt_q;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= sucs_pkg::CAP_RESET;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			cnt_q  <= cnt_d;
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			sucs_pkg::OP_LOAD: begin
				func_q <= sucs_pkg::func_t'(func);
				key_q  <= key;
				idx_q  <= '0;
				pos_q  <= '0;
			end
			sucs_pkg::OP_SCAN_NEXT, sucs_pkg::OP_DN_STEP, sucs_pkg::OP_DUMP_STEP: begin
				idx_q <= idx_p1;
			end
			sucs_pkg::OP_INS_PRIME: begin
				pos_q <= ge ? idx_q : idx_p1;
				idx_q <= cnt_q;
			end
			sucs_pkg::OP_UP_STEP: begin
				idx_q <= idx_m1;
			end
			default: begin
			end
		endcase
		if (cmd.emit) begin
			status_q <= cmd.status;
			value_q  <= cmd.dump_val ? rkey : 8'sd0;
			last_q   <= cmd.last;
			count_q  <= 7'(cnt_d);
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign value  = value_q;
	assign last   = last_q;
	assign count  = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("held count exceeds the store depth");

	a_cnt_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> done_q)
		else $error("held count changed without a result");

	a_place_below_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == sucs_pkg::OP_PLACE) |-> (cnt_q < CW'(DEPTH)))
		else $error("insert placed into a full store");

endmodule

FILE: rtl/sucs_ctrl.sv
`timescale 1ns / 1ps

module sucs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sucs_pkg::sts_t sts,
	output sucs_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_SCAN     = 7'b0000100,
		S_SH_UP    = 7'b0001000,
		S_PLACE    = 7'b0010000,
		S_SH_DN    = 7'b0100000,
		S_DUMP     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd.op       = sucs_pkg::OP_NOP;
		cmd.emit     = 1'b0;
		cmd.status   = sucs_pkg::STAT_DONE;
		cmd.last     = 1'b1;
		cmd.dump_val = 1'b0;
		cmd.cnt_op   = sucs_pkg::CNT_KEEP;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = sucs_pkg::OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.func)
					sucs_pkg::FUNC_INSERT: begin
						if (sts.full) begin
							cmd.emit   = 1'b1;
							cmd.status = sucs_pkg::STAT_FULL;
							state_d    = S_IDLE;
						end else if (sts.empty) begin
							state_d = S_PLACE;
						end else begin
							state_d = S_SCAN;
						end
					end
					sucs_pkg::FUNC_REMOVE, sucs_pkg::FUNC_SEARCH: begin
						if (sts.empty) begin
							cmd.emit   = 1'b1;
							cmd.status = sucs_pkg::STAT_ABSENT;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					sucs_pkg::FUNC_DUMP: begin
						if (sts.empty) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end else begin
							state_d = S_DUMP;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (!(sts.ge || sts.idx_last)) begin
					cmd.op = sucs_pkg::OP_SCAN_NEXT;
				end else begin
					unique case (sts.func)
						sucs_pkg::FUNC_INSERT: begin
							if (sts.eq) begin
								cmd.emit   = 1'b1;
								cmd.status = sucs_pkg::STAT_DUP;
								state_d    = S_IDLE;
							end else begin
								cmd.op  = sucs_pkg::OP_INS_PRIME;
								state_d = sts.ge ? S_SH_UP : S_PLACE;
							end
						end
						sucs_pkg::FUNC_REMOVE: begin
							if (!sts.eq) begin
								cmd.emit   = 1'b1;
								cmd.status = sucs_pkg::STAT_ABSENT;
								state_d    = S_IDLE;
							end else if (sts.idx_last) begin
								cmd.emit   = 1'b1;
								cmd.cnt_op = sucs_pkg::CNT_DEC;
								state_d    = S_IDLE;
							end else begin
								cmd.op  = sucs_pkg::OP_DN_PRIME;
								state_d = S_SH_DN;
							end
						end
						sucs_pkg::FUNC_SEARCH: begin
							cmd.emit   = 1'b1;
							cmd.status = sts.eq ? sucs_pkg::STAT_DONE : sucs_pkg::STAT_ABSENT;
							state_d    = S_IDLE;
						end
						sucs_pkg::FUNC_DUMP: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SH_UP: begin
				cmd.op = sucs_pkg::OP_UP_STEP;
				if (sts.up_end) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op     = sucs_pkg::OP_PLACE;
				cmd.emit   = 1'b1;
				cmd.cnt_op = sucs_pkg::CNT_INC;
				state_d    = S_IDLE;
			end
			S_SH_DN: begin
				cmd.op = sucs_pkg::OP_DN_STEP;
				if (sts.dn_end) begin
					cmd.emit   = 1'b1;
					cmd.cnt_op = sucs_pkg::CNT_DEC;
					state_d    = S_IDLE;
				end
			end
			S_DUMP: begin
				cmd.op       = sucs_pkg::OP_DUMP_STEP;
				cmd.emit     = 1'b1;
				cmd.dump_val = 1'b1;
				cmd.last     = sts.idx_last;
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == S_IDLE))
		else $error("command did not finish with its final result");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!cmd.emit && cmd.cnt_op == sucs_pkg::CNT_KEEP))
		else $error("result or count change while idle");

	a_more_only_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !cmd.last) |-> (state_q == S_DUMP))
		else $error("non-final result outside a dump");

endmodule

FILE: rtl/sorted_unique_char_set.sv
`timescale 1ns / 1ps

// Channel    Direction  Signals                              Transfer
// command    in         start, busy, func, key               start high while busy low
// result     out        done, status, value, last, count     done high, one cycle
// config     in         cfg_valid, cfg_ready, cfg_data       cfg_valid and cfg_ready high
//
// An accepted request passes through dispatch and then steps through each stored key it
// scans or moves, as the single read port of the key store gives one entry a cycle.
// A dump strobes its n results on consecutive cycles, and an empty dump a single result.
// Reset clears the held count and sets the capacity to 64; the store itself is not
// cleared. Results cannot be stalled, and busy falls as the final result appears.

module sorted_unique_char_set #(
	parameter int DEPTH = sucs_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic signed [7:0] key,
	output logic              done,
	output logic [1:0]        status,
	output logic signed [7:0] value,
	output logic              last,
	output logic [6:0]        count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data
);

	sucs_pkg::cmd_t cmd;
	sucs_pkg::sts_t sts;

	sucs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	sucs_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.key       (key),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.status    (status),
		.value     (value),
		.last      (last),
		.count     (count)
	);

endmodule

FILE: tb/sucs_checker.sv
`timescale 1ns / 1ps

module sucs_checker
	import sucs_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        func,
	input  logic signed [7:0] key,
	input  logic              done,
	input  logic [1:0]        status,
	input  logic signed [7:0] value,
	input  logic              last,
	input  logic [6:0]        count,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [6:0]        cfg_data,
	output int                errors,
	output int                pending,
	output int                n_requests,
	output int                n_results
);

	typedef struct {
		status_t           status;
		logic signed [7:0] value;
		logic              last;
		logic [6:0]        count;
	} result_t;

	logic signed [7:0] set_keys [DEPTH];
	int                held;
	logic [6:0]        cap;
	result_t           outstanding [$];
	int                mismatches = 0;
	int                requests_seen = 0;
	int                results_seen = 0;

	assign errors     = mismatches;
	assign n_requests = requests_seen;
	assign n_results  = results_seen;

	function automatic int find_key(input logic signed [7:0] k);
		for (int i = 0; i < held; i++)
			if (set_keys[i] == k)
				return i;
		return held;
	endfunction

	function automatic void note_result(input status_t s, input logic signed [7:0] v,
					    input logic l);
		result_t r;
		r.status = s;
		r.value  = v;
		r.last   = l;
		r.count  = 7'(held);
		outstanding.push_back(r);
	endfunction

	task automatic run_request(input func_t f, input logic signed [7:0] k);
		int pos;
		int lim;
		lim = (int'(cap) < DEPTH) ? int'(cap) : DEPTH;
		pos = find_key(k);
		case (f)
			FUNC_INSERT: begin
				if (held >= lim) begin
					note_result(STAT_FULL, 8'sd0, 1'b1);
				end else if (pos != held) begin
					note_result(STAT_DUP, 8'sd0, 1'b1);
				end else begin
					pos = 0;
					while (pos < held && set_keys[pos] < k)
						pos++;
					for (int i = held; i > pos; i--)
						set_keys[i] = set_keys[i - 1];
					set_keys[pos] = k;
					held++;
					note_result(STAT_DONE, 8'sd0, 1'b1);
				end
			end
			FUNC_REMOVE: begin
				if (pos >= held) begin
					note_result(STAT_ABSENT, 8'sd0, 1'b1);
				end else begin
					for (int i = pos; i + 1 < held; i++)
						set_keys[i] = set_keys[i + 1];
					held--;
					note_result(STAT_DONE, 8'sd0, 1'b1);
				end
			end
			FUNC_SEARCH: begin
				if (pos < held)
					note_result(STAT_DONE, 8'sd0, 1'b1);
				else
					note_result(STAT_ABSENT, 8'sd0, 1'b1);
			end
			default: begin
				if (held == 0)
					note_result(STAT_DONE, 8'sd0, 1'b1);
				for (int i = 0; i < held; i++)
					note_result(STAT_DONE, set_keys[i], i == held - 1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			outstanding.delete();
			held = 0;
			cap = CAP_RESET;
			pending <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (outstanding.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result status %0d value %0d last %0d count %0d",
							 $time, status, value, last, count);
				end else begin
					want = outstanding.pop_front();
					if (status !== want.status || value !== want.value ||
					    last !== want.last || count !== want.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch, expected status %0d value %0d last %0d count %0d, got status %0d value %0d last %0d count %0d",
								 $time, want.status, want.value, want.last, want.count,
								 status, value, last, count);
					end
				end
			end
			if (start && !busy) begin
				requests_seen++;
				run_request(func_t'(func), key);
			end
			if (cfg_valid && cfg_ready)
				cap = cfg_data;
			pending <= outstanding.size();
		end
	end

endmodule

FILE: tb/tb_sorted_unique_char_set.sv
`timescale 1ns / 1ps

module tb_sorted_unique_char_set;
	import sucs_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        func = FUNC_INSERT;
	logic signed [7:0] key = 8'sd0;
	logic              done;
	logic [1:0]        status;
	logic signed [7:0] value;
	logic              last;
	logic [6:0]        count;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [6:0]        cfg_data = 7'd0;

	int                errors;
	int                pending;
	int                n_requests;
	int                n_results;
	int                cap_writes = 0;
	logic signed [7:0] sent_keys [$];

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("** sorted_unique_char_set: FAILED **");
		$finish;
	end

	sorted_unique_char_set i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.key       (key),
		.done      (done),
		.status    (status),
		.value     (value),
		.last      (last),
		.count     (count),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sucs_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.key        (key),
		.done       (done),
		.status     (status),
		.value      (value),
		.last       (last),
		.count      (count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending),
		.n_requests (n_requests),
		.n_results  (n_results)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic signed [7:0] pick_key(input int spread);
		if ($urandom_range(0, 99) < spread || sent_keys.size() == 0)
			return 8'($urandom_range(0, 255));
		return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
	endfunction

	task automatic issue(input func_t f, input logic signed [7:0] k, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			func <= 2'($urandom_range(0, 3));
			key <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		key <= k;
		if (f == FUNC_INSERT)
			sent_keys.push_back(k);
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [6:0] c);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	task automatic random_run(input int n, input int ins_pct, input int rem_pct,
				  input int spread);
		func_t f;
		int    r;
		bit    calm;
		calm = 1'b0;
		for (int j = 0; j < n; j++) begin
			if (j % 16 == 0)
				calm = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				f = FUNC_INSERT;
			else if (r < ins_pct + rem_pct)
				f = FUNC_REMOVE;
			else if (r < 90)
				f = FUNC_SEARCH;
			else
				f = FUNC_DUMP;
			issue(f, pick_key(spread), calm ? 0 : gap_len());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(FUNC_DUMP, 8'sd0, gap_len());
		issue(FUNC_SEARCH, 8'sd0, gap_len());
		issue(FUNC_REMOVE, 8'sd5, gap_len());
		issue(FUNC_INSERT, 8'sd0, gap_len());
		issue(FUNC_INSERT, -8'sd128, gap_len());
		issue(FUNC_INSERT, 8'sd127, gap_len());
		issue(FUNC_INSERT, -8'sd1, gap_len());
		issue(FUNC_INSERT, 8'sd1, gap_len());
		issue(FUNC_INSERT, 8'sd0, gap_len());
		issue(FUNC_SEARCH, 8'sd127, gap_len());
		issue(FUNC_SEARCH, -8'sd128, gap_len());
		issue(FUNC_SEARCH, 8'sd2, gap_len());
		issue(FUNC_REMOVE, 8'sd2, gap_len());
		issue(FUNC_DUMP, -8'sd1, gap_len());
		issue(FUNC_REMOVE, -8'sd128, gap_len());
		issue(FUNC_REMOVE, 8'sd127, gap_len());
		issue(FUNC_DUMP, 8'sd0, gap_len());

		// The capacity drops below the number of keys already held.
		set_capacity(7'd2);
		issue(FUNC_INSERT, 8'sd50, gap_len());
		issue(FUNC_INSERT, 8'sd0, gap_len());
		issue(FUNC_REMOVE, 8'sd0, gap_len());
		issue(FUNC_INSERT, 8'sd0, gap_len());
		issue(FUNC_REMOVE, 8'sd1, gap_len());
		issue(FUNC_INSERT, 8'sd0, gap_len());
		issue(FUNC_DUMP, 8'sd0, gap_len());
		set_capacity(7'd0);
		issue(FUNC_INSERT, 8'sd3, gap_len());

		// Distinct keys fill the store to its depth and beyond, with a capacity above it.
		set_capacity(7'd127);
		for (int j = 0; j < 66; j++)
			issue(FUNC_INSERT, 8'(3 * j - 100), gap_len());
		issue(FUNC_DUMP, 8'sd0, gap_len());
		set_capacity(7'($urandom_range(2, 10)));
		random_run(24, 20, 55, 10);
		set_capacity(7'd1);
		random_run(12, 50, 25, 30);
		set_capacity(7'd0);
		random_run(8, 50, 25, 30);
		set_capacity(7'd64);
		random_run(16, 40, 30, 30);

		settle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d requests and %0d results over %0d capacity settings,",
			 n_requests, n_results, cap_writes + 1);
		$display("among them capacities 0, 1, 64 and 127 with the store filled to its depth.");
		if (errors == 0)
			$display("** sorted_unique_char_set: PASSED **");
		else
			$display("** sorted_unique_char_set: FAILED **");
		$finish;
	end

endmodule
